### design/ovle_pkg.sv
// Shared types and constants for the ordered value list engine.
package ovle_pkg;

  localparam int unsigned OVLE_DEPTH = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ST_W       = 3;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned VAL_W      = 31;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_MOD  = 2'd2,
    OP_DUMP = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE       = 3'd0,
    ST_IGNORED    = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_FULL       = 3'd4,
    ST_ENTRY      = 3'd5,
    ST_DUMP_EMPTY = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_ADD   = 2'd1,
    WR_MOD   = 2'd2,
    WR_SHIFT = 2'd3
  } wr_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_HIT,
    S_MISS,
    S_SHIFT,
    S_DEL_FIN,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    ptr_load_top;
    logic    ptr_load_next;
    logic    dir_up;
    logic    rd_en;
    logic    hold_rd;
    logic    pos_load;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    logic    emit_entry;
    status_e emit_status;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic key_pos;
    logic new_pos;
    logic cnt_zero;
    logic cnt_full;
    logic rvld;
    logic rd_done;
    logic match;
    logic raddr_zero;
    logic raddr_top;
    logic pos_top;
    logic out_free;
  } sts_t;

endpackage

### design/ovle_dpath.sv
// Datapath: operand registers, entry memory, scan pointer, count and result register.
module ovle_dpath #(
  parameter int unsigned LIST_DEPTH = ovle_pkg::OVLE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ovle_pkg::cmd_t                   cmd_i,
  output ovle_pkg::sts_t                   sts_o,
  // [31:0] key_value, [63:32] new_value
  input  logic [2*ovle_pkg::KEY_W-1:0]     s_tdata_i,
  // [1:0] operation
  input  logic [ovle_pkg::OP_W-1:0]        s_tuser_i,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  // [30:0] item_value, [31] zero fill
  output logic [ovle_pkg::KEY_W-1:0]       m_tdata_o,
  // [2:0] status
  output logic [ovle_pkg::ST_W-1:0]        m_tuser_o,
  output logic                             m_tlast_o
);
  import ovle_pkg::*;

  localparam int unsigned IdxW = $clog2(LIST_DEPTH);
  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);

  op_e              op_q;
  logic [KEY_W-1:0] key_q, new_q;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_m1;
  logic [IdxW-1:0]  cnt_top_idx;
  logic [VAL_W-1:0] mem [LIST_DEPTH];
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic [IdxW-1:0]  raddr_q, pos_q;
  logic [VAL_W-1:0] rdata_q;
  logic             rvld_q, rvld_d;
  logic             rd_done_q, rd_done_d;
  logic             rd_last;
  logic             wr_en;
  logic [IdxW-1:0]  waddr;
  logic [VAL_W-1:0] wdata;
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q;
  logic [VAL_W-1:0] out_value_q;
  logic             out_last_q;

  assign cnt_m1      = cnt_q - CntW'(1);
  assign cnt_top_idx = cnt_m1[IdxW-1:0];
  assign rd_last     = cmd_i.dir_up ? (ptr_q == cnt_top_idx) : (ptr_q == '0);

  // Operand capture and match position
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(s_tuser_i);
      key_q <= s_tdata_i[KEY_W-1:0];
      new_q <= s_tdata_i[2*KEY_W-1:KEY_W];
    end
    if (cmd_i.pos_load) begin
      pos_q <= raddr_q;
    end
  end

  // Write port select
  always_comb begin
    wr_en = 1'b1;
    waddr = '0;
    wdata = '0;
    case (cmd_i.wr_sel)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_ADD: begin
        waddr = cnt_q[IdxW-1:0];
        wdata = key_q[VAL_W-1:0];
      end
      WR_MOD: begin
        waddr = pos_q;
        wdata = new_q[VAL_W-1:0];
      end
      WR_SHIFT: begin
        // move the entry one slot toward the old end
        waddr = raddr_q - IdxW'(1);
        wdata = rdata_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[ptr_q];
      raddr_q <= ptr_q;
    end
  end

  always_comb begin
    ptr_d     = ptr_q;
    rd_done_d = rd_done_q;
    if (cmd_i.ptr_load_top) begin
      ptr_d     = cnt_top_idx;
      rd_done_d = 1'b0;
    end else if (cmd_i.ptr_load_next) begin
      ptr_d     = pos_q + IdxW'(1);
      rd_done_d = 1'b0;
    end else if (cmd_i.rd_en) begin
      ptr_d     = cmd_i.dir_up ? ptr_q + IdxW'(1) : ptr_q - IdxW'(1);
      rd_done_d = rd_last;
    end
  end

  assign rvld_d = cmd_i.rd_en | (rvld_q & cmd_i.hold_rd);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_m1;
    end
  end

  assign out_valid_d = cmd_i.emit | (out_valid_q & ~m_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      rvld_q      <= 1'b0;
      rd_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      rvld_q      <= rvld_d;
      rd_done_q   <= rd_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_value_q  <= cmd_i.emit_entry ? rdata_q : '0;
      out_last_q   <= cmd_i.emit_entry ? (raddr_q == '0) : 1'b1;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, out_value_q};
  assign m_tuser_o  = out_status_q;
  assign m_tlast_o  = out_last_q;

  assign sts_o.op         = op_q;
  assign sts_o.key_pos    = (key_q != '0) && !key_q[KEY_W-1];
  assign sts_o.new_pos    = (new_q != '0) && !new_q[KEY_W-1];
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.cnt_full   = (cnt_q == CntW'(LIST_DEPTH));
  assign sts_o.rvld       = rvld_q;
  assign sts_o.rd_done    = rd_done_q;
  assign sts_o.match      = ({1'b0, rdata_q} == key_q);
  assign sts_o.raddr_zero = (raddr_q == '0);
  assign sts_o.raddr_top  = (raddr_q == cnt_top_idx);
  assign sts_o.pos_top    = (pos_q == cnt_top_idx);
  assign sts_o.out_free   = !out_valid_q || m_tready_i;

endmodule

### design/ovle_ctrl.sv
// Controller: sequences decode, search, compaction and dump over the datapath.
module ovle_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output ovle_pkg::cmd_t cmd_o,
  input  ovle_pkg::sts_t sts_i
);
  import ovle_pkg::*;

  state_e  state_q, state_d;
  logic    reply;
  status_e reply_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    reply    = 1'b0;
    reply_st = ST_DONE;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_ADD: begin
            reply = 1'b1;
            if (!sts_i.key_pos) begin
              reply_st = ST_IGNORED;
            end else if (sts_i.cnt_full) begin
              reply_st = ST_FULL;
            end else if (sts_i.out_free) begin
              cmd_o.wr_sel  = WR_ADD;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          OP_DEL: begin
            if (!sts_i.key_pos) begin
              reply    = 1'b1;
              reply_st = ST_IGNORED;
            end else if (sts_i.cnt_zero) begin
              reply    = 1'b1;
              reply_st = ST_EMPTY;
            end else begin
              cmd_o.ptr_load_top = 1'b1;
              state_d            = S_SCAN;
            end
          end
          OP_MOD: begin
            if (!sts_i.new_pos) begin
              reply    = 1'b1;
              reply_st = ST_IGNORED;
            end else if (sts_i.cnt_zero) begin
              reply    = 1'b1;
              reply_st = ST_NOT_FOUND;
            end else begin
              cmd_o.ptr_load_top = 1'b1;
              state_d            = S_SCAN;
            end
          end
          OP_DUMP: begin
            if (sts_i.cnt_zero) begin
              reply    = 1'b1;
              reply_st = ST_DUMP_EMPTY;
            end else begin
              cmd_o.ptr_load_top = 1'b1;
              state_d            = S_DUMP_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        // search from newest to oldest; the compare sees the read data in the cycle after the read
        cmd_o.rd_en = !sts_i.rd_done;
        if (sts_i.rvld && sts_i.match) begin
          cmd_o.pos_load = 1'b1;
          state_d        = S_HIT;
        end else if (sts_i.rvld && sts_i.raddr_zero) begin
          state_d = S_MISS;
        end
      end
      S_HIT: begin
        if (sts_i.op == OP_MOD) begin
          if (sts_i.out_free) begin
            cmd_o.wr_sel = WR_MOD;
          end
          reply = 1'b1;
        end else if (sts_i.pos_top) begin
          state_d = S_DEL_FIN;
        end else begin
          cmd_o.ptr_load_next = 1'b1;
          state_d             = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.dir_up = 1'b1;
        cmd_o.rd_en  = !sts_i.rd_done;
        if (sts_i.rvld) begin
          cmd_o.wr_sel = WR_SHIFT;
          if (sts_i.raddr_top) begin
            state_d = S_DEL_FIN;
          end
        end
      end
      S_DEL_FIN: begin
        reply         = 1'b1;
        cmd_o.cnt_dec = sts_i.out_free;
      end
      S_MISS: begin
        reply    = 1'b1;
        reply_st = ST_NOT_FOUND;
      end
      S_DUMP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        // hold the fetched entry until the result register frees up
        cmd_o.hold_rd = 1'b1;
        if (sts_i.rvld && sts_i.out_free) begin
          cmd_o.hold_rd     = 1'b0;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_entry  = 1'b1;
          cmd_o.emit_status = ST_ENTRY;
          if (sts_i.raddr_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (reply && sts_i.out_free) begin
      cmd_o.emit        = 1'b1;
      cmd_o.emit_status = reply_st;
      state_d           = S_IDLE;
    end
  end

endmodule

### design/ordered_value_list_engine.sv
// Top level of the ordered value list engine: bounded newest-first list of positive values.
//
//   channel  dir  handshake                 payload
//   s_axis   in   s_axis_tvalid/tready      tuser operation; tdata key_value, new_value
//   m_axis   out  m_axis_tvalid/tready      tuser status; tdata item_value; tlast last_item
//
// Add and every case settled at decode pass through accept and decode, then the output wait.
// Delete and modify scan the entry memory newest first at one entry per cycle; delete then
// compacts at one entry per cycle after the match. Dump passes through a read state, then
// streams the entries newest first while the sink is ready. The entry memory has a single
// read port with registered read data. Reset empties the list at once; no clearing pass.
// The result register lets a new item in while the last result still waits; a stalled
// sink freezes dump and every final result.
module ordered_value_list_engine #(
  parameter int unsigned LIST_DEPTH = ovle_pkg::OVLE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [31:0] key_value, [63:32] new_value
  input  logic [2*ovle_pkg::KEY_W-1:0] s_axis_tdata,
  // [1:0] operation
  input  logic [ovle_pkg::OP_W-1:0]    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [30:0] item_value, [31] zero fill
  output logic [ovle_pkg::KEY_W-1:0]   m_axis_tdata,
  // [2:0] status
  output logic [ovle_pkg::ST_W-1:0]    m_axis_tuser,
  output logic                         m_axis_tlast
);
  import ovle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ovle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  ovle_dpath #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tready_i(m_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser),
    .m_tlast_o (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result loaded while output register still occupied");

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !sts.rvld)
    else $error("stale read data pending while accepting a new item");

  a_capture_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> (cmd.wr_sel == WR_NONE) && !cmd.cnt_inc && !cmd.cnt_dec)
    else $error("list state changed in the cycle a transaction is accepted");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !sts.cnt_full && (cmd.wr_sel == WR_ADD))
    else $error("entry count advanced without a legal add");
`endif

endmodule
